>>> rtl/dsfs_pkg.sv
// Shared constants, types, and elaboration-time tables for the dual sine flicker shaper.
package dsfs_pkg;

  // Sizes
  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int LOG_TABLE_DEPTH  = 256;

  localparam int SINE_AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER    = SINE_TABLE_DEPTH / 4;
  localparam int QUARTER_AW = SINE_AW - 2;
  localparam int LOG_AW     = $clog2(LOG_TABLE_DEPTH);

  // Phase increment: (p * 1/(2*pi) in Q32) >> INC_SHIFT
  localparam int          INC_SHIFT      = 52 - PHASE_BITS;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  // Shared multiplier shape
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Floors
  localparam logic [15:0] EXP_FLOOR   = 16'd41;
  localparam logic [15:0] PULSE_FLOOR = 16'd41;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIME_SCALE        = 3'd0,
    REG_PRIMARY_SPEED     = 3'd1,
    REG_SECONDARY_SPEED   = 3'd2,
    REG_MIX_WEIGHT        = 3'd3,
    REG_RESPONSE_EXPONENT = 3'd4,
    REG_COLOR_SCALE_MIN   = 3'd5,
    REG_COLOR_SCALE_MAX   = 3'd6,
    REG_PULSE_AMPLITUDE   = 3'd7
  } dsfs_reg_t;

  typedef struct packed {
    logic [15:0] time_scale;
    logic [15:0] primary_speed;
    logic [15:0] secondary_speed;
    logic [16:0] mix_weight;
    logic [15:0] response_exponent;
    logic [15:0] color_scale_min;
    logic [15:0] color_scale_max;
    logic [15:0] pulse_amplitude;
  } dsfs_cfg_t;

  // Head of the tick queue
  typedef struct packed {
    logic        valid;
    logic [15:0] dt;
  } dsfs_head_t;

  typedef logic [15:0] sine_rom_t [QUARTER];
  typedef logic [15:0] log_rom_t  [LOG_TABLE_DEPTH];
  typedef logic [16:0] exp_rom_t  [LOG_TABLE_DEPTH];

  // Secondary phase start: 0.73 rad in turns, scaled to PHASE_BITS
  function automatic logic [PHASE_BITS-1:0] sec_phase_init();
    logic [95:0] v;
    v = 96'd499002651;
    if (PHASE_BITS >= 32) v = v << (PHASE_BITS - 32);
    else                  v = v >> (32 - PHASE_BITS);
    return v[PHASE_BITS-1:0];
  endfunction

  // sin(pi/2 * x), x and result in Q2.30
  function automatic logic [63:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995    - ((p * x2) >> 30);
    p  = 64'd85569306   - ((p * x2) >> 30);
    p  = 64'd693598668  - ((p * x2) >> 30);
    p  = 64'd1686629713 - ((p * x2) >> 30);
    return (p * x) >> 30;
  endfunction

  // 16 fraction bits of log2(x), x in Q1.30 in [1,2)
  function automatic logic [15:0] frac_log2(input logic [63:0] x_in);
    logic [63:0] x;
    logic [15:0] r;
    x = x_in;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      r = {r[14:0], 1'b0};
      if (x >= 64'd2147483648) begin
        r[0] = 1'b1;
        x    = x >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [16:0] log_of_level(input logic [63:0] v);
    if (v >= 64'd65536) return 17'd65536;
    return {1'b0, frac_log2(v << 15)};
  endfunction

  // Quarter-wave sine magnitude of entry i, 0..QUARTER
  function automatic logic [15:0] sine_mag(input int i);
    logic [63:0] x;
    logic [63:0] s;
    x = ((64'(i) * 64'd4) << 30) / SINE_TABLE_DEPTH;
    s = (quarter_sine(x) + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[15:0];
  endfunction

  // Quarter-wave sine magnitudes, entries 0..QUARTER-1
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < QUARTER; i++) rom[i] = sine_mag(i);
    return rom;
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t    rom;
    logic [63:0] x;
    for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
      x      = ((64'(LOG_TABLE_DEPTH) + 64'(k)) << 30) / LOG_TABLE_DEPTH;
      rom[k] = frac_log2(x);
    end
    return rom;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
      target = 64'd65536 - (64'(k) * 64'd65536) / LOG_TABLE_DEPTH;
      lo     = 64'd32768;
      hi     = 64'd65536;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (64'(log_of_level(mid)) <= target) lo = mid;
        else                                   hi = mid - 64'd1;
      end
      rom[k] = lo[16:0];
    end
    return rom;
  endfunction

  localparam logic [PHASE_BITS-1:0] SEC_PHASE_INIT = sec_phase_init();
  localparam sine_rom_t   SINE_ROM  = build_sine_rom();
  localparam logic [15:0] SINE_PEAK = sine_mag(QUARTER);
  localparam log_rom_t    LOG_ROM   = build_log_rom();
  localparam exp_rom_t    EXP_ROM   = build_exp_rom();

  // Raised sine (32768 + s, or 32768 - s in the second half-wave) of a phase, from the quarter-wave table
  function automatic logic [15:0] raised_sine(input logic [PHASE_BITS-1:0] phase);
    logic [SINE_AW-1:0]  idx;
    logic [QUARTER_AW:0] addr;
    logic [15:0]         s;
    idx = phase[PHASE_BITS-1 -: SINE_AW];
    if (idx[SINE_AW-2]) addr = (QUARTER_AW+1)'(QUARTER) - {1'b0, idx[QUARTER_AW-1:0]};
    else                addr = {1'b0, idx[QUARTER_AW-1:0]};
    // The quarter-wave peak sits just past the table
    if (addr[QUARTER_AW]) s = SINE_PEAK;
    else                  s = SINE_ROM[addr[QUARTER_AW-1:0]];
    if (idx[SINE_AW-1]) return 16'd32768 - s;
    return 16'd32768 + s;
  endfunction

endpackage

>>> rtl/dsfs_front.sv
// Front end: accepts tick transactions into a two-entry queue for the engine.
module dsfs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_tick_dt,
  output dsfs_pkg::dsfs_head_t head,
  input  logic                pop
);
  import dsfs_pkg::*;

  logic [15:0] slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        do_pop;

  // Stall when both slots hold a tick
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.dt    = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming tick
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= in_tick_dt;
  end

endmodule

>>> rtl/dsfs_engine.sv
// Back end: sequences one shared multiplier through phase update, mix, shaping and scaling.
module dsfs_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsfs_pkg::dsfs_cfg_t  cfg,
  input  dsfs_pkg::dsfs_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [16:0]          out_flicker_level,
  output logic [15:0]          out_color_scale,
  output logic [15:0]          out_pulse_scale
);
  import dsfs_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_DTTS = 17'h00002,
    S_PSPD = 17'h00004,
    S_PK   = 17'h00008,
    S_PADD = 17'h00010,
    S_SK   = 17'h00020,
    S_SADD = 17'h00040,
    S_SINE = 17'h00080,
    S_MIXA = 17'h00100,
    S_MIXB = 17'h00200,
    S_MIXS = 17'h00400,
    S_LOG  = 17'h00800,
    S_POW  = 17'h01000,
    S_EXP  = 17'h02000,
    S_COL  = 17'h04000,
    S_PUL  = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PHASE_BITS-1:0]   phase_p_r, phase_p_nxt;
  logic [PHASE_BITS-1:0]   phase_s_r, phase_s_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [15:0]             dt_r;
  logic [31:0]             dtts_r;
  logic [PROD_W-1:0]       prod_r;
  logic [15:0]             a_r, b_r;
  logic [32:0]             acc_r;
  logic [15:0]             mixed_r;
  logic [20:0]             mag_r;
  logic                    zero_r;
  logic [16:0]             level_r;
  logic [15:0]             cs_r;
  logic [16:0]             flicker_r;
  logic [15:0]             color_r;
  logic [15:0]             pulse_r;

  logic                    mul_en;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       inc_full;
  logic [16:0]             w_eff;
  logic [16:0]             w_inv;
  logic [15:0]             e_eff;
  logic [15:0]             cmax;
  logic [15:0]             cdiff;
  logic [33:0]             mix_sum;
  logic [3:0]              lead;
  logic [15:0]             norm;
  logic [20:0]             mag;
  logic [38:0]             q_sum;
  logic [25:0]             q;
  logic [16:0]             level;
  logic [33:0]             cs_sum;
  logic [16:0]             cs_full;
  logic                    up;
  logic [17:0]             lvl2;
  logic [16:0]             dev;
  logic [33:0]             term_sum;
  logic [16:0]             term;
  logic [17:0]             pulse_up;
  logic [15:0]             pulse;
  logic                    load;

  // Clamp configuration values
  always_comb begin
    w_eff = (cfg.mix_weight > 17'd65536) ? 17'd65536 : cfg.mix_weight;
    w_inv = 17'd65536 - w_eff;
    e_eff = (cfg.response_exponent < EXP_FLOOR) ? EXP_FLOOR : cfg.response_exponent;
    cmax  = (cfg.color_scale_max < cfg.color_scale_min) ? cfg.color_scale_min
                                                         : cfg.color_scale_max;
    cdiff = cmax - cfg.color_scale_min;
  end

  // Select multiplier operands per step
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_DTTS: begin
        mul_a = MUL_A_W'(dt_r);
        mul_b = MUL_B_W'(cfg.time_scale);
      end
      S_PSPD: begin
        mul_a = prod_r[31:0];
        mul_b = MUL_B_W'(cfg.primary_speed);
      end
      S_PK: begin
        mul_a = prod_r[47:16];
        mul_b = MUL_B_W'(INV_TWO_PI_Q32);
      end
      S_PADD: begin
        mul_a = dtts_r;
        mul_b = MUL_B_W'(cfg.secondary_speed);
      end
      S_SK: begin
        mul_a = prod_r[47:16];
        mul_b = MUL_B_W'(INV_TWO_PI_Q32);
      end
      S_MIXA: begin
        mul_a = MUL_A_W'(a_r);
        mul_b = MUL_B_W'(w_inv);
      end
      S_MIXB: begin
        mul_a = MUL_A_W'(b_r);
        mul_b = MUL_B_W'(w_eff);
      end
      S_POW: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(e_eff);
      end
      S_COL: begin
        mul_a = MUL_A_W'(cdiff);
        mul_b = MUL_B_W'(level_r);
      end
      S_PUL: begin
        mul_a = MUL_A_W'(dev);
        mul_b = MUL_B_W'(cfg.pulse_amplitude);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign inc_full = prod_r >> INC_SHIFT;

  // Mix rounding
  assign mix_sum = 34'(acc_r) + 34'(prod_r[32:0]) + 34'd32768;

  // Find the leading one of the mix and look up its log
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mixed_r[i]) lead = 4'(i);
    end
    norm = mixed_r << (4'd15 - lead);
    mag  = ({17'(5'd16 - {1'b0, lead}), 4'd0} << 12)
           - 21'(LOG_ROM[norm[14 -: LOG_AW]]);
  end

  // Exponentiate the scaled log
  always_comb begin
    q_sum = prod_r[38:0] + 39'd2048;
    q     = q_sum[37:12];
    if (zero_r || (q[25:16] >= 10'd17)) level = 17'd0;
    else level = EXP_ROM[q[15 -: LOG_AW]] >> q[20:16];
  end

  // Colour lerp and pulse deviation
  always_comb begin
    cs_sum  = 34'(prod_r[32:0]) + 34'd32768;
    cs_full = 17'(cfg.color_scale_min) + cs_sum[32:16];
    up      = (level_r >= 17'd32768);
    lvl2    = {level_r, 1'b0};
    dev     = up ? 17'(lvl2 - 18'd65536) : 17'(18'd65536 - lvl2);
  end

  // Pulse with saturation on both sides
  always_comb begin
    term_sum = 34'(prod_r[32:0]) + 34'd32768;
    term     = term_sum[32:16];
    pulse_up = 18'd4096 + 18'(term);
    if (up) pulse = (pulse_up > 18'd65535) ? 16'hffff : pulse_up[15:0];
    else if ((18'(term) + 18'(PULSE_FLOOR)) >= 18'd4096) pulse = PULSE_FLOOR;
    else pulse = 16'(17'd4096 - term);
  end

  assign load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign pop  = (state_r == S_IDLE) && head.valid;

  // Step the sequence
  always_comb begin
    state_nxt     = state_r;
    phase_p_nxt   = phase_p_r;
    phase_s_nxt   = phase_s_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: if (head.valid) state_nxt = S_DTTS;
      S_DTTS: state_nxt = S_PSPD;
      S_PSPD: state_nxt = S_PK;
      S_PK:   state_nxt = S_PADD;
      S_PADD: begin
        phase_p_nxt = phase_p_r + inc_full[PHASE_BITS-1:0];
        state_nxt   = S_SK;
      end
      S_SK:   state_nxt = S_SADD;
      S_SADD: begin
        phase_s_nxt = phase_s_r + inc_full[PHASE_BITS-1:0];
        state_nxt   = S_SINE;
      end
      S_SINE: state_nxt = S_MIXA;
      S_MIXA: state_nxt = S_MIXB;
      S_MIXB: state_nxt = S_MIXS;
      S_MIXS: state_nxt = S_LOG;
      S_LOG:  state_nxt = S_POW;
      S_POW:  state_nxt = S_EXP;
      S_EXP:  state_nxt = S_COL;
      S_COL:  state_nxt = S_PUL;
      S_PUL:  state_nxt = S_OUT;
      S_OUT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_p_r   <= '0;
      phase_s_r   <= SEC_PHASE_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_p_r   <= phase_p_nxt;
      phase_s_r   <= phase_s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold datapath values per step
  always_ff @(posedge clk) begin
    if (pop)               dt_r    <= head.dt;
    if (mul_en)            prod_r  <= prod;
    if (state_r == S_PSPD) dtts_r  <= prod_r[31:0];
    if (state_r == S_SINE) begin
      a_r <= raised_sine(phase_p_r);
      b_r <= raised_sine(phase_s_r);
    end
    if (state_r == S_MIXB) acc_r   <= prod_r[32:0];
    if (state_r == S_MIXS) mixed_r <= mix_sum[31:16];
    if (state_r == S_LOG) begin
      mag_r  <= mag;
      zero_r <= (mixed_r == 16'd0);
    end
    if (state_r == S_EXP)  level_r <= level;
    if (state_r == S_PUL)  cs_r    <= (cs_full > 17'd65535) ? 16'hffff : cs_full[15:0];
    if (load) begin
      flicker_r <= level_r;
      color_r   <= cs_r;
      pulse_r   <= pulse;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_flicker_level = flicker_r;
  assign out_color_scale   = color_r;
  assign out_pulse_scale   = pulse_r;

`ifndef ASSERT_OFF
  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT)) else $error("result without final step");
  a_pulse_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pulse_r >= PULSE_FLOOR)) else $error("pulse below floor");
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (flicker_r <= 17'd65536)) else $error("level above one");
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == S_DTTS)) else $error("pop did not start sequence");
`endif

endmodule

>>> rtl/dual_sine_flicker_shaper_unit.sv
// Top level: configuration registers, tick queue and shaping engine.
// Each tick transaction runs through the engine's step sequence from the head
// of the queue to a registered result: ten multiplications run one after another
// through a single shared 32x33 multiplier, interleaved with sine, log2 and exp2
// table lookups. A two-entry queue takes ticks while the engine works, and the
// result register holds a finished transaction while the next tick starts; the
// engine itself takes a new tick only after the last one has left its final step.
// Phases persist across configuration changes; configuration writes are taken
// at any time and should be made while no tick is in flight.
module dual_sine_flicker_shaper_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_tick_dt,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_flicker_level,
  output logic [15:0] out_color_scale,
  output logic [15:0] out_pulse_scale,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import dsfs_pkg::*;

  dsfs_cfg_t  cfg_r;
  dsfs_head_t head;
  logic       pop;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_scale        <= 16'd4096;
      cfg_r.primary_speed     <= 16'd256;
      cfg_r.secondary_speed   <= 16'd256;
      cfg_r.mix_weight        <= 17'd0;
      cfg_r.response_exponent <= 16'd4096;
      cfg_r.color_scale_min   <= 16'd4096;
      cfg_r.color_scale_max   <= 16'd4096;
      cfg_r.pulse_amplitude   <= 16'd0;
    end else if (cfg_we) begin
      unique case (dsfs_reg_t'(cfg_index))
        REG_TIME_SCALE:        cfg_r.time_scale        <= cfg_data[15:0];
        REG_PRIMARY_SPEED:     cfg_r.primary_speed     <= cfg_data[15:0];
        REG_SECONDARY_SPEED:   cfg_r.secondary_speed   <= cfg_data[15:0];
        REG_MIX_WEIGHT:        cfg_r.mix_weight        <= cfg_data;
        REG_RESPONSE_EXPONENT: cfg_r.response_exponent <= cfg_data[15:0];
        REG_COLOR_SCALE_MIN:   cfg_r.color_scale_min   <= cfg_data[15:0];
        REG_COLOR_SCALE_MAX:   cfg_r.color_scale_max   <= cfg_data[15:0];
        REG_PULSE_AMPLITUDE:   cfg_r.pulse_amplitude   <= cfg_data[15:0];
        default:               cfg_r                   <= cfg_r;
      endcase
    end
  end

  dsfs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tick_dt (in_tick_dt),
    .head       (head),
    .pop        (pop)
  );

  dsfs_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_flicker_level (out_flicker_level),
    .out_color_scale   (out_color_scale),
    .out_pulse_scale   (out_pulse_scale)
  );

endmodule

>>> bench/tb_dual_sine_flicker_shaper_unit.sv
// Self-checking bench for the dual sine flicker shaper: directed table, then random ticks.
module tb_dual_sine_flicker_shaper_unit;
  import dsfs_pkg::*;

  typedef struct packed {
    logic [16:0] level;
    logic [15:0] color;
    logic [15:0] pulse;
  } flicker_out_t;

  typedef struct {
    bit           is_cfg;
    dsfs_reg_t    idx;
    logic [16:0]  val;
    logic [15:0]  dt;
    bit           typed;
    flicker_out_t want;
  } stim_row_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_tick_dt = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] out_flicker_level;
  logic [15:0] out_color_scale;
  logic [15:0] out_pulse_scale;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  dual_sine_flicker_shaper_unit dut (.*);

  // Model state
  logic [15:0]  sine_lut [SINE_TABLE_DEPTH];
  logic [15:0]  log_lut  [LOG_TABLE_DEPTH];
  logic [16:0]  exp_lut  [LOG_TABLE_DEPTH];
  logic [16:0]  regs [8];
  logic [31:0]  phase_a;
  logic [31:0]  phase_b;
  flicker_out_t pending_levels [$];
  stim_row_t    rows [$];

  int  mismatches = 0;
  int  cycles = 0;
  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  int  holds_asked = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  bit  valid_hi = 0;
  bit  cfg_hi = 0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Table builders
  function automatic longint unsigned qw_sin(longint unsigned x);
    longint unsigned x2, p;
    x2 = (x * x) >> 30;
    p = 172272;
    p = 5026995 - ((p * x2) >> 30);
    p = 85569306 - ((p * x2) >> 30);
    p = 693598668 - ((p * x2) >> 30);
    p = 1686629713 - ((p * x2) >> 30);
    return (p * x) >> 30;
  endfunction

  function automatic longint unsigned lg_frac(longint unsigned x_in);
    longint unsigned x, r;
    x = x_in;
    r = 0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= 64'd2147483648) begin
        r = r | 1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned lg_level(longint unsigned v);
    if (v >= 65536) return 65536;
    return lg_frac(v << 15);
  endfunction

  function automatic void fill_luts();
    longint unsigned q, quad, x, s, tgt, lo, hi, mid;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q = k * 4;
      quad = q / SINE_TABLE_DEPTH;
      x = ((q % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
      if (quad[0]) x = 64'd1073741824 - x;
      s = (qw_sin(x) + 16384) >> 15;
      if (s > 32767) s = 32767;
      sine_lut[k] = quad[1] ? 16'(32768 - s) : 16'(32768 + s);
    end
    for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
      x = ((longint'(LOG_TABLE_DEPTH) + k) << 30) / LOG_TABLE_DEPTH;
      log_lut[k] = 16'(lg_frac(x));
      tgt = 65536 - (longint'(k) * 65536) / LOG_TABLE_DEPTH;
      lo = 32768;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (lg_level(mid) <= tgt) lo = mid;
        else hi = mid - 1;
      end
      exp_lut[k] = 17'(lo);
    end
  endfunction

  function automatic void regs_to_reset();
    regs[REG_TIME_SCALE]        = 17'd4096;
    regs[REG_PRIMARY_SPEED]     = 17'd256;
    regs[REG_SECONDARY_SPEED]   = 17'd256;
    regs[REG_MIX_WEIGHT]        = 17'd0;
    regs[REG_RESPONSE_EXPONENT] = 17'd4096;
    regs[REG_COLOR_SCALE_MIN]   = 17'd4096;
    regs[REG_COLOR_SCALE_MAX]   = 17'd4096;
    regs[REG_PULSE_AMPLITUDE]   = 17'd0;
    phase_a = 32'd0;
    phase_b = 32'd499002651;
  endfunction

  function automatic logic [31:0] phase_step(logic [15:0] dt, logic [16:0] speed);
    longint unsigned p;
    p = (longint'(dt) * regs[REG_TIME_SCALE] * speed) >> 16;
    return 32'((p * 64'd683565276) >> 20);
  endfunction

  // Raise the mix to the response exponent through the log2/exp2 tables
  function automatic longint unsigned power_shape(longint unsigned m, longint unsigned e);
    int n;
    longint unsigned fr, ix, mag, q, ip;
    if (m == 0) return 0;
    if (m >= 65536) return 65536;
    n = 15;
    while (n > 0 && m[n] == 1'b0) n--;
    fr = (m << (15 - n)) & 64'h7fff;
    ix = (fr * LOG_TABLE_DEPTH) >> 15;
    mag = longint'(16 - n) * 65536 - log_lut[ix];
    q = (mag * e + 2048) >> 12;
    ip = q >> 16;
    if (ip >= 17) return 0;
    ix = ((q & 64'hffff) * LOG_TABLE_DEPTH) >> 16;
    return longint'(exp_lut[ix]) >> ip;
  endfunction

  // Advance both oscillators by one tick and derive the three outputs
  function automatic flicker_out_t advance_flicker(logic [15:0] dt);
    flicker_out_t r;
    longint unsigned a, b, w, m, e, lvl, cmin, cmax, cs, d, term, pl;
    bit up;
    phase_a = phase_a + phase_step(dt, regs[REG_PRIMARY_SPEED]);
    phase_b = phase_b + phase_step(dt, regs[REG_SECONDARY_SPEED]);
    a = sine_lut[phase_a[31:22]];
    b = sine_lut[phase_b[31:22]];
    w = regs[REG_MIX_WEIGHT] > 65536 ? 65536 : regs[REG_MIX_WEIGHT];
    m = (a * (65536 - w) + b * w + 32768) >> 16;
    e = regs[REG_RESPONSE_EXPONENT] < 41 ? 41 : regs[REG_RESPONSE_EXPONENT];
    lvl = power_shape(m, e);
    cmin = regs[REG_COLOR_SCALE_MIN];
    cmax = regs[REG_COLOR_SCALE_MAX] < cmin ? cmin : regs[REG_COLOR_SCALE_MAX];
    cs = cmin + (((cmax - cmin) * lvl + 32768) >> 16);
    if (cs > 65535) cs = 65535;
    up = (2 * lvl) >= 65536;
    d = up ? (2 * lvl - 65536) : (65536 - 2 * lvl);
    term = (d * regs[REG_PULSE_AMPLITUDE] + 32768) >> 16;
    if (up) pl = (4096 + term > 65535) ? 65535 : 4096 + term;
    else    pl = (term + 41 >= 4096) ? 41 : 4096 - term;
    r.level = 17'(lvl);
    r.color = 16'(cs);
    r.pulse = 16'(pl);
    return r;
  endfunction

  // Receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked > holds_done) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Compare each result transaction with the oldest pending expected result
  always @(posedge clk) begin
    flicker_out_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_flicker_level, out_color_scale, out_pulse_scale};
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result level=%0d color=%0d pulse=%0d",
                   got.level, got.color, got.pulse);
      end else begin
        want = pending_levels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want level=%0d color=%0d pulse=%0d, got %0d %0d %0d",
                     want.level, want.color, want.pulse, got.level, got.color, got.pulse);
        end
      end
    end
  end

  // Offer one tick, hold it until taken, then maybe idle
  task automatic send_tick(logic [15:0] dt, bit typed, flicker_out_t want);
    flicker_out_t p;
    int gap;
    in_valid <= 1'b1;
    in_tick_dt <= dt;
    valid_hi = 1;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    p = advance_flicker(dt);
    pending_levels.push_back(typed ? want : p);
    @(posedge clk);
    if ($urandom_range(99) < in_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      valid_hi = 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every pending result has arrived
  task automatic drain();
    if (valid_hi) begin
      in_valid <= 1'b0;
      valid_hi = 0;
    end
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(dsfs_reg_t ix, logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= v;
    cfg_hi = 1;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    regs[ix] = (ix == REG_MIX_WEIGHT) ? v : {1'b0, v[15:0]};
    @(posedge clk);
  endtask

  task automatic end_cfg();
    if (cfg_hi) begin
      cfg_valid <= 1'b0;
      cfg_hi = 0;
    end
  endtask

  function automatic logic [16:0] pick_value(dsfs_reg_t ix);
    int sel;
    sel = $urandom_range(5);
    if (sel == 0) return 17'd0;
    if (sel == 1) return (ix == REG_MIX_WEIGHT) ? 17'd65536 : 17'd65535;
    if (ix == REG_MIX_WEIGHT) return (sel == 2) ? 17'($urandom_range(131071))
                                                : 17'($urandom_range(65536));
    return 17'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] pick_dt();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return 16'($urandom_range(65535));
    if (sel < 8) return 16'($urandom_range(2047));
    return (sel == 8) ? 16'd0 : 16'd65535;
  endfunction

  function automatic void add_cfg(dsfs_reg_t ix, logic [16:0] v);
    rows.push_back('{1'b1, ix, v, 16'd0, 1'b0, '0});
  endfunction

  function automatic void add_tick(logic [15:0] dt);
    rows.push_back('{1'b0, REG_TIME_SCALE, 17'd0, dt, 1'b0, '0});
  endfunction

  // Stimulus
  initial begin
    flicker_out_t none;
    int per_seg;
    none = '0;
    fill_luts();
    regs_to_reset();

    // Directed rows: reset state, exponent floor, deep power, clamps
    rows.push_back('{1'b0, REG_TIME_SCALE, 17'd0, 16'd0, 1'b1,
                     '{17'd32768, 16'd4096, 16'd4096}});
    add_tick(16'd65535);
    add_tick(16'd1);
    add_cfg(REG_RESPONSE_EXPONENT, 17'd0);
    add_tick(16'd4000);
    add_cfg(REG_RESPONSE_EXPONENT, 17'd65535);
    add_tick(16'd9000);
    add_cfg(REG_RESPONSE_EXPONENT, 17'd4096);
    add_cfg(REG_MIX_WEIGHT, 17'd131071);
    add_cfg(REG_COLOR_SCALE_MIN, 17'd65535);
    add_cfg(REG_COLOR_SCALE_MAX, 17'd0);
    add_cfg(REG_PULSE_AMPLITUDE, 17'd65535);
    add_tick(16'd12000);
    add_tick(16'd30000);
    add_cfg(REG_MIX_WEIGHT, 17'd65536);
    add_cfg(REG_COLOR_SCALE_MIN, 17'd0);
    add_cfg(REG_COLOR_SCALE_MAX, 17'd65535);
    add_tick(16'd20000);
    add_tick(16'd45000);
    add_cfg(REG_TIME_SCALE, 17'd65535);
    add_cfg(REG_PRIMARY_SPEED, 17'd65535);
    add_cfg(REG_SECONDARY_SPEED, 17'd65535);
    add_tick(16'd65535);
    add_tick(16'd65535);
    add_cfg(REG_TIME_SCALE, 17'd0);
    add_tick(16'd65535);

    // Reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        end_cfg();
        drain();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        end_cfg();
        send_tick(rows[i].dt, rows[i].typed, rows[i].typed ? rows[i].want : none);
      end
    end
    end_cfg();

    // Random segments over the idling modes, new settings between them
    per_seg = 116;
    for (int seg = 0; seg < 8; seg++) begin
      drain();
      for (int r = 0; r < 8; r++) write_reg(dsfs_reg_t'(r), pick_value(dsfs_reg_t'(r)));
      end_cfg();
      case (seg / 2)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 63; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 63; end
        default: begin in_idle_pct = 31; out_stall_pct = 31; end
      endcase
      if (seg == 0) holds_asked++;
      for (int n = 0; n < per_seg; n++) begin
        if (seg == 3 && n == 50) drain();
        send_tick(pick_dt(), 1'b0, none);
      end
    end
    drain();

    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dsfs_pkg.sv
rtl/dsfs_front.sv
rtl/dsfs_engine.sv
rtl/dual_sine_flicker_shaper_unit.sv
bench/tb_dual_sine_flicker_shaper_unit.sv
